### hdl/plar_pkg.sv
// Shared constants and types for the polyline arc-length resampler.
`default_nettype none
package plar_pkg;
   localparam int MAX_POINTS = 1024;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int COORD_W    = 32;
   localparam int ARC_W      = 48;
   localparam int OC_W       = 7;
   localparam int OUT_MAX    = 64;
   localparam int DIV_W      = 6;
   localparam int PROD_W     = ARC_W + DIV_W;
   localparam int FRAC_BITS  = 30;
   localparam int SQ_W       = 2 * (COORD_W + 1);
   localparam int ROOT_W     = COORD_W + 1;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_OUT_COUNT = CSR_ADDR_W'(0);

   typedef struct packed {
      logic [ARC_W-1:0]          arc;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage
`default_nettype wire

### hdl/plar_if.sv
// Request and response channel interfaces of the resampler.
`default_nettype none
interface plar_req_if;
   import plar_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] in_x;
   logic signed [COORD_W-1:0] in_y;
   logic                      in_last;
   modport source (output valid, output in_x, output in_y, output in_last, input ready);
   modport sink   (input valid, input in_x, input in_y, input in_last, output ready);
endinterface

interface plar_rsp_if;
   import plar_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic                      out_last;
   logic                      truncated;
   modport source (output valid, output out_x, output out_y, output out_last,
                   output truncated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_last,
                   input truncated, output ready);
endinterface
`default_nettype wire

### hdl/plar_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hdl/plar_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module plar_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plar_pkg::SQ_W-1:0]      radicand,
   output logic                           done,
   output logic [plar_pkg::ROOT_W-1:0]    root
);
   import plar_pkg::*;

   localparam int REM_W = ROOT_W + 3;

   logic [SQ_W-1:0]   work_ff, work_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W+1:0]  shifted;
   logic [REM_W+1:0]  trial;

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, work_ff[SQ_W-1 -: 2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      if (start) begin
         work_in = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[SQ_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = REM_W'(shifted - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

### hdl/plar_fdiv.sv
// Restoring fraction divider: quotient bits of num/den for num < den.
`default_nettype none
module plar_fdiv (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [plar_pkg::PROD_W-1:0]      num,
   input  logic [plar_pkg::PROD_W-1:0]      den,
   output logic                             done,
   output logic [plar_pkg::FRAC_BITS-1:0]   quo
);
   import plar_pkg::*;

   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]    den_ff, den_in;
   logic [FRAC_BITS-1:0] quo_ff, quo_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [PROD_W:0]      shifted;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, 1'b0};
      if (start) begin
         rem_in  = num;
         den_in  = den;
         quo_in  = '0;
         cnt_in  = 5'(FRAC_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= (PROD_W+1)'(den_ff)) begin
            rem_in = PROD_W'(shifted - (PROD_W+1)'(den_ff));
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[PROD_W-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

### hdl/polyline_arc_length_resample.sv
// Polyline arc-length resampler: top level with point store and run sequencer.
// Load: a request is taken only when idle; each stored point passes the squaring
//   states, the bit-serial square root and one store write; the first only writes.
// Run: the last point starts a run of out_count responses (clamped to 2..64); each
//   interior response scans vertices, divides if needed, then interpolates x and y.
// Reset: synchronous; clears the point count, overflow flag and handshakes and
//   sets out_count to 64. The point store itself is never cleared.
`default_nettype none
module polyline_arc_length_resample (
   input  logic                            clock,
   input  logic                            reset,
   plar_req_if.sink                        req_ch,
   plar_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [plar_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [plar_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [plar_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import plar_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_WRITE,
      ST_RD0, ST_RD1, ST_RD2, ST_SEL, ST_SMUL, ST_SCAN, ST_SWAIT,
      ST_CALC, ST_DIV, ST_LXM, ST_LXA, ST_LYM, ST_LYA, ST_EMIT
   } state_type;

   localparam logic [ARC_W:0] ARC_LIMIT = {1'b0, {ARC_W{1'b1}}};

   state_type                 state_ff, state_in;
   logic [OC_W-1:0]           out_count_ff, out_count_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      flag_ff, flag_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic                      last_ff, last_in;
   logic [SQ_W-2:0]           sq_ff, sq_in;
   logic [ROOT_W-1:0]         seg_ff, seg_in;
   entry_type                 prev_ff, prev_in;
   logic signed [COORD_W-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [DIV_W-1:0]          div_ff, div_in;
   logic [DIV_W-1:0]          i_ff, i_in;
   logic [IDX_W-1:0]          j_ff, j_in;
   entry_type                 lo_ff, lo_in, hi_ff, hi_in;
   logic [PROD_W-1:0]         goal_ff, goal_in, lo_prod_ff, lo_prod_in, hi_prod_ff, hi_prod_in;
   logic [FRAC_BITS:0]        t_ff, t_in;
   logic [63:0]               lprod_ff, lprod_in;
   logic                      lneg_ff, lneg_in;
   logic signed [COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic                      olast_ff, olast_in, otrunc_ff, otrunc_in;
   logic                      rvalid_ff, rvalid_in;

   // Datapath temporaries.
   logic signed [COORD_W:0]   dxc, dyc, ldiff;
   logic [COORD_W:0]          ax, ay, lmag;
   logic [SQ_W-1:0]           radicand;
   logic [ARC_W:0]            arc_sum;
   logic [ARC_W-1:0]          arc_new;
   logic [PROD_W-1:0]         w1, dd;
   logic signed [COORD_W-1:0] lc0, lc1;
   logic [63:0]               lsum;
   logic [COORD_W+1:0]        off, lres, lbase;
   logic                      sqrt_start, sqrt_done, div_start, div_done;
   logic [ROOT_W-1:0]         root;
   logic [FRAC_BITS-1:0]      quo;
   logic                      wr_en;
   entry_type                 wr_entry;
   logic [IDX_W-1:0]          rd_addr;
   logic [ENTRY_W-1:0]        rd_data;
   entry_type                 rd_entry;
   logic                      csr_wr;
   logic [OC_W-1:0]           m_clamp;

   assign rd_entry = entry_type'(rd_data);
   assign csr_wr   = psel && penable && pwrite && (paddr == CSR_OUT_COUNT);
   assign pready   = 1'b1;
   assign prdata   = (paddr == CSR_OUT_COUNT) ? CSR_DATA_W'(out_count_ff) : '0;

   // Clamp the output count into its legal range.
   assign m_clamp  = (out_count_ff < OC_W'(2)) ? OC_W'(2) :
                     (out_count_ff > OC_W'(OUT_MAX)) ? OC_W'(OUT_MAX) : out_count_ff;

   // Segment length: squared deltas against the previously stored point.
   always_comb begin
      dxc      = (COORD_W+1)'(px_ff) - (COORD_W+1)'(prev_ff.x);
      dyc      = (COORD_W+1)'(py_ff) - (COORD_W+1)'(prev_ff.y);
      ax       = dxc[COORD_W] ? (COORD_W+1)'(-dxc) : (COORD_W+1)'(dxc);
      ay       = dyc[COORD_W] ? (COORD_W+1)'(-dyc) : (COORD_W+1)'(dyc);
      radicand = SQ_W'(sq_ff) + ay * ay;
      arc_sum  = (ARC_W+1)'(prev_ff.arc) + (ARC_W+1)'(seg_ff);
      arc_new  = (count_ff == '0) ? '0 :
                 (arc_sum > ARC_LIMIT) ? ARC_LIMIT[ARC_W-1:0] : arc_sum[ARC_W-1:0];
      wr_entry = '{arc: arc_new, x: px_ff, y: py_ff};
   end

   // Interpolation: one shared multiplier, x in the LX states, y in the LY states.
   always_comb begin
      w1    = goal_ff - lo_prod_ff;
      dd    = hi_prod_ff - lo_prod_ff;
      lc0   = (state_ff == ST_LYM || state_ff == ST_LYA) ? lo_ff.y : lo_ff.x;
      lc1   = (state_ff == ST_LYM || state_ff == ST_LYA) ? hi_ff.y : hi_ff.x;
      ldiff = (COORD_W+1)'(lc1) - (COORD_W+1)'(lc0);
      lmag  = ldiff[COORD_W] ? (COORD_W+1)'(-ldiff) : (COORD_W+1)'(ldiff);
      lsum  = lprod_ff + (64'd1 << (FRAC_BITS - 1));
      off   = lsum[FRAC_BITS +: COORD_W+2];
      lbase = (COORD_W+2)'(lc0);
      lres  = lneg_ff ? lbase - off : lbase + off;
   end

   always_comb begin
      rd_addr = j_ff + IDX_W'(1);
      case (state_ff)
         ST_RD0:  rd_addr = '0;
         ST_RD1:  rd_addr = IDX_W'(1);
         default: rd_addr = j_ff + IDX_W'(1);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      out_count_in = csr_wr ? pwdata[OC_W-1:0] : out_count_ff;
      count_in     = count_ff;
      flag_in      = flag_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      seg_in       = seg_ff;
      prev_in      = prev_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      div_in       = div_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      goal_in      = goal_ff;
      lo_prod_in   = lo_prod_ff;
      hi_prod_in   = hi_prod_ff;
      t_in         = t_ff;
      lprod_in     = lprod_ff;
      lneg_in      = lneg_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      olast_in     = olast_ff;
      otrunc_in    = otrunc_ff;
      rvalid_in    = rvalid_ff;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      wr_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               px_in   = req_ch.in_x;
               py_in   = req_ch.in_y;
               last_in = req_ch.in_last;
               if (count_ff == CNT_W'(MAX_POINTS)) begin
                  // Drop the point; a dropped last point still starts the run.
                  flag_in  = 1'b1;
                  state_in = req_ch.in_last ? ST_RD0 : ST_IDLE;
               end else if (count_ff == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            sq_in    = (SQ_W-1)'(ax * ax);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               seg_in   = root;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            prev_in  = wr_entry;
            count_in = count_ff + CNT_W'(1);
            if (count_ff == '0) begin
               first_x_in = px_ff;
               first_y_in = py_ff;
            end
            state_in = last_ff ? ST_RD0 : ST_IDLE;
         end
         ST_RD0: begin
            // Latch the divisor and prime the scan window.
            div_in   = DIV_W'(m_clamp - OC_W'(1));
            i_in     = '0;
            j_in     = IDX_W'(1);
            state_in = ST_RD1;
         end
         ST_RD1: begin
            lo_in      = rd_entry;
            lo_prod_in = '0;
            state_in   = ST_RD2;
         end
         ST_RD2: begin
            hi_in    = rd_entry;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            olast_in  = (i_ff == div_ff);
            otrunc_in = flag_ff;
            if (i_ff == '0 || prev_ff.arc == '0) begin
               ox_in     = first_x_ff;
               oy_in     = first_y_ff;
               rvalid_in = 1'b1;
               state_in  = ST_EMIT;
            end else if (i_ff == div_ff) begin
               ox_in     = prev_ff.x;
               oy_in     = prev_ff.y;
               rvalid_in = 1'b1;
               state_in  = ST_EMIT;
            end else begin
               goal_in  = prev_ff.arc * i_ff;
               state_in = ST_SMUL;
            end
         end
         ST_SMUL: begin
            hi_prod_in = hi_ff.arc * div_ff;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            // Advance while the upper vertex still lies below the target.
            if (hi_prod_ff < goal_ff) begin
               lo_in      = hi_ff;
               lo_prod_in = hi_prod_ff;
               j_in       = j_ff + IDX_W'(1);
               state_in   = ST_SWAIT;
            end else begin
               state_in = ST_CALC;
            end
         end
         ST_SWAIT: begin
            hi_in    = rd_entry;
            state_in = ST_SMUL;
         end
         ST_CALC: begin
            if (dd == '0 || w1 >= dd) begin
               t_in     = (FRAC_BITS+1)'(1) << FRAC_BITS;
               state_in = ST_LXM;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               t_in     = (FRAC_BITS+1)'(quo);
               state_in = ST_LXM;
            end
         end
         ST_LXM, ST_LYM: begin
            lprod_in = 64'(lmag * t_ff);
            lneg_in  = ldiff[COORD_W];
            state_in = (state_ff == ST_LXM) ? ST_LXA : ST_LYA;
         end
         ST_LXA: begin
            ox_in    = lres[COORD_W-1:0];
            state_in = ST_LYM;
         end
         ST_LYA: begin
            oy_in     = lres[COORD_W-1:0];
            rvalid_in = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold the response until taken; the final one closes the trajectory.
            if (rsp_ch.ready) begin
               rvalid_in = 1'b0;
               if (i_ff == div_ff) begin
                  count_in = '0;
                  flag_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + DIV_W'(1);
                  state_in = ST_SEL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_count_ff <= OC_W'(OUT_MAX);
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_count_ff <= out_count_in;
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         rvalid_ff    <= rvalid_in;
      end
      px_ff      <= px_in;
      py_ff      <= py_in;
      last_ff    <= last_in;
      sq_ff      <= sq_in;
      seg_ff     <= seg_in;
      prev_ff    <= prev_in;
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      div_ff     <= div_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      goal_ff    <= goal_in;
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
      t_ff       <= t_in;
      lprod_ff   <= lprod_in;
      lneg_ff    <= lneg_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      olast_ff   <= olast_in;
      otrunc_ff  <= otrunc_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rvalid_ff;
   assign rsp_ch.out_x     = ox_ff;
   assign rsp_ch.out_y     = oy_ff;
   assign rsp_ch.out_last  = olast_ff;
   assign rsp_ch.truncated = otrunc_ff;

   plar_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   plar_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   plar_fdiv u_fdiv (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (w1),
      .den   (dd),
      .done  (div_done),
      .quo   (quo)
   );
endmodule
`default_nettype wire
